// ----- hw/rtl/smacc_pkg.sv -----
package smacc_pkg;

  localparam int unsigned NumScale = 3;
  localparam int unsigned NumAcc   = 6;
  localparam int unsigned NumSteps = NumScale + NumAcc;
  localparam int unsigned StepW    = $clog2(NumSteps + 1);
  localparam int unsigned AccIdxW  = $clog2(NumAcc);
  localparam int unsigned AxisW    = $clog2(NumScale);
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned SumW     = 64;
  localparam int unsigned MulW     = DataW + 1;

  localparam logic [DataW-1:0] ScaleReset = 32'h0001_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCALE  = 3'd0,
    REG_MEAN_U = 3'd1,
    REG_MEAN_V = 3'd2,
    REG_MEAN_W = 3'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             capture;
    logic             mul_en;
    logic [StepW-1:0] mul_step;
    logic             wb_en;
    logic [StepW-1:0] wb_step;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // Axis of the first factor of each accumulated product.
  function automatic logic [AxisW-1:0] prod_axis_a(logic [AccIdxW-1:0] idx);
    logic [AxisW-1:0] r;
    unique case (idx)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd1;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Axis of the second factor of each accumulated product.
  function automatic logic [AxisW-1:0] prod_axis_b(logic [AccIdxW-1:0] idx);
    logic [AxisW-1:0] r;
    unique case (idx)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd0;
      3'd2:    r = 2'd1;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/smacc_ctrl.sv -----
module smacc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  smacc_pkg::status_t status_i,
  output smacc_pkg::cmd_t    cmd_o
);
  import smacc_pkg::*;

  state_e           state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.mul_step = cnt_q;
    cmd_o.wb_step  = cnt_q - StepW'(1);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = '0;
          state_d       = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.wb_en  = (cnt_q != '0);
        cnt_d        = cnt_q + StepW'(1);
        if (cnt_q == StepW'(NumSteps - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.wb_en = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.last) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/smacc_dp.sv -----
module smacc_dp #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smacc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [smacc_pkg::DataW-1:0]   cfg_wdata_i,
  input  logic [smacc_pkg::DataW-1:0]   coord_u_i,
  input  logic [smacc_pkg::DataW-1:0]   coord_v_i,
  input  logic [smacc_pkg::DataW-1:0]   coord_w_i,
  input  logic                          last_i,
  input  smacc_pkg::cmd_t               cmd_i,
  output smacc_pkg::status_t            status_o,
  output logic [smacc_pkg::SumW-1:0]    sum_o [smacc_pkg::NumAcc],
  output logic                          overflow_o
);
  import smacc_pkg::*;

  logic [DataW-1:0] scale_q;
  logic [DataW-1:0] mean_q  [NumScale];
  logic [DataW-1:0] coord_q [NumScale];
  logic [DataW-1:0] cen_q   [NumScale];
  logic [SumW-1:0]  acc_q   [NumAcc];
  logic [SumW-1:0]  sum_q   [NumAcc];
  logic [SumW-1:0]  prod_q;
  logic             last_q;
  logic             sat_q;
  logic             ovf_q;

  logic [DataW-1:0] coord_in [NumScale];
  logic [DataW-1:0] coord_raw [NumScale];

  logic [AccIdxW-1:0] mul_acc_idx, wb_acc_idx;
  logic [AxisW-1:0]   mul_axis, wb_axis;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] mul_full;

  logic signed [SumW-16:0] diff;
  logic [DataW-1:0]        cen_d;
  logic                    cen_sat;
  logic [SumW:0]           acc_sum;
  logic [SumW-1:0]         acc_d;
  logic                    acc_sat;
  logic                    wb_scale;

  assign coord_raw[0] = coord_u_i;
  assign coord_raw[1] = coord_v_i;
  assign coord_raw[2] = coord_w_i;

  for (genvar g = 0; g < NumScale; g++) begin : g_sext
    assign coord_in[g] = {{(DataW - COORD_WIDTH){coord_raw[g][COORD_WIDTH-1]}},
                          coord_raw[g][COORD_WIDTH-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      for (int i = 0; i < NumScale; i++) begin
        mean_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCALE:  scale_q   <= cfg_wdata_i;
        REG_MEAN_U: mean_q[0] <= cfg_wdata_i;
        REG_MEAN_V: mean_q[1] <= cfg_wdata_i;
        REG_MEAN_W: mean_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < NumScale; i++) begin
        coord_q[i] <= coord_in[i];
      end
      last_q <= last_i;
    end
  end

  assign mul_acc_idx = AccIdxW'(cmd_i.mul_step - StepW'(NumScale));
  assign mul_axis    = cmd_i.mul_step[AxisW-1:0];

  always_comb begin
    if (cmd_i.mul_step < StepW'(NumScale)) begin
      mul_a = $signed({coord_q[mul_axis][DataW-1], coord_q[mul_axis]});
      mul_b = $signed({1'b0, scale_q});
    end else begin
      mul_a = $signed({cen_q[prod_axis_a(mul_acc_idx)][DataW-1],
                       cen_q[prod_axis_a(mul_acc_idx)]});
      mul_b = $signed({cen_q[prod_axis_b(mul_acc_idx)][DataW-1],
                       cen_q[prod_axis_b(mul_acc_idx)]});
    end
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_full[SumW-1:0];
    end
  end

  assign wb_scale   = (cmd_i.wb_step < StepW'(NumScale));
  assign wb_axis    = cmd_i.wb_step[AxisW-1:0];
  assign wb_acc_idx = AccIdxW'(cmd_i.wb_step - StepW'(NumScale));

  always_comb begin
    diff = $signed({prod_q[SumW-1], prod_q[SumW-1:16]})
         - $signed({{(SumW - 15 - DataW){mean_q[wb_axis][DataW-1]}}, mean_q[wb_axis]});
    cen_sat = (diff[SumW-16:DataW-1] != {(SumW - 14 - DataW){diff[DataW-1]}});
    if (!cen_sat) begin
      cen_d = diff[DataW-1:0];
    end else if (diff[SumW-16]) begin
      cen_d = {1'b1, {(DataW - 1){1'b0}}};
    end else begin
      cen_d = {1'b0, {(DataW - 1){1'b1}}};
    end
  end

  always_comb begin
    acc_sum = {acc_q[wb_acc_idx][SumW-1], acc_q[wb_acc_idx]} + {prod_q[SumW-1], prod_q};
    acc_sat = (acc_sum[SumW] != acc_sum[SumW-1]);
    if (!acc_sat) begin
      acc_d = acc_sum[SumW-1:0];
    end else if (acc_sum[SumW]) begin
      acc_d = {1'b1, {(SumW - 1){1'b0}}};
    end else begin
      acc_d = {1'b0, {(SumW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_en && wb_scale) begin
      cen_q[wb_axis] <= cen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAcc; i++) begin
        acc_q[i] <= '0;
      end
      sat_q <= 1'b0;
    end else if (cmd_i.emit) begin
      for (int i = 0; i < NumAcc; i++) begin
        acc_q[i] <= '0;
      end
      sat_q <= 1'b0;
    end else if (cmd_i.wb_en) begin
      if (wb_scale) begin
        sat_q <= sat_q | cen_sat;
      end else begin
        acc_q[wb_acc_idx] <= acc_d;
        sat_q             <= sat_q | acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      for (int i = 0; i < NumAcc; i++) begin
        sum_q[i] <= acc_q[i];
      end
      ovf_q <= sat_q;
    end
  end

  assign status_o.last = last_q;
  assign sum_o         = sum_q;
  assign overflow_o    = ovf_q;

endmodule

// ----- hw/rtl/scatter_matrix_3d_accumulator.sv -----
// Accumulates the six distinct entries of the 3x3 scatter matrix of a stream of
// points: each coordinate is scaled by the Q16.16 scale register, the mean is
// subtracted with saturation, and the products uu, vu, vv, wu, wv and ww are summed
// into saturating Q32.32 accumulators; the word marked last emits the sums with an
// overflow flag and clears them. One shared 33x33 multiplier does three scaling
// steps and six product steps per point, so a point occupies the block from
// acceptance until it is ready again; a last word waits longer only while
// the previous result word is still held on the output.
module scatter_matrix_3d_accumulator #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smacc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [smacc_pkg::DataW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [smacc_pkg::DataW-1:0]   coord_u_i,
  input  logic [smacc_pkg::DataW-1:0]   coord_v_i,
  input  logic [smacc_pkg::DataW-1:0]   coord_w_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [smacc_pkg::SumW-1:0]    sum_uu_o,
  output logic [smacc_pkg::SumW-1:0]    sum_vu_o,
  output logic [smacc_pkg::SumW-1:0]    sum_vv_o,
  output logic [smacc_pkg::SumW-1:0]    sum_wu_o,
  output logic [smacc_pkg::SumW-1:0]    sum_wv_o,
  output logic [smacc_pkg::SumW-1:0]    sum_ww_o,
  output logic                          overflow_o
);
  import smacc_pkg::*;

  cmd_t            cmd;
  status_t         status;
  logic [SumW-1:0] sums [NumAcc];

  smacc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smacc_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coord_u_i   (coord_u_i),
    .coord_v_i   (coord_v_i),
    .coord_w_i   (coord_w_i),
    .last_i      (last_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .sum_o       (sums),
    .overflow_o  (overflow_o)
  );

  assign sum_uu_o = sums[0];
  assign sum_vu_o = sums[1];
  assign sum_vv_o = sums[2];
  assign sum_wu_o = sums[3];
  assign sum_wv_o = sums[4];
  assign sum_ww_o = sums[5];

endmodule

// ----- tb/sv/scatter_matrix_3d_accumulator_checker.sv -----
`timescale 1ns / 1ps

module scatter_matrix_3d_accumulator_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smacc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [smacc_pkg::DataW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [smacc_pkg::DataW-1:0]   coord_u_i,
  input  logic [smacc_pkg::DataW-1:0]   coord_v_i,
  input  logic [smacc_pkg::DataW-1:0]   coord_w_i,
  input  logic                          last_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [smacc_pkg::SumW-1:0]    sum_uu_i,
  input  logic [smacc_pkg::SumW-1:0]    sum_vu_i,
  input  logic [smacc_pkg::SumW-1:0]    sum_vv_i,
  input  logic [smacc_pkg::SumW-1:0]    sum_wu_i,
  input  logic [smacc_pkg::SumW-1:0]    sum_wv_i,
  input  logic [smacc_pkg::SumW-1:0]    sum_ww_i,
  input  logic                          overflow_i,
  output int                            mismatch_count_o,
  output int                            pending_sums_o
);
  import smacc_pkg::*;

  localparam logic signed [SumW-1:0] CenterMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [SumW-1:0] CenterMin = ~CenterMax;
  localparam int unsigned FactorA [NumAcc] = '{0, 1, 1, 2, 2, 2};
  localparam int unsigned FactorB [NumAcc] = '{0, 0, 1, 0, 1, 2};
  localparam string SumNames [NumAcc] = '{"sum_uu", "sum_vu", "sum_vv",
                                          "sum_wu", "sum_wv", "sum_ww"};

  typedef struct packed {
    logic [NumAcc-1:0][SumW-1:0] sums;
    logic                        overflow;
  } scatter_sums_t;

  logic [DataW-1:0]       scale_q;
  logic [DataW-1:0]       mean_q [NumScale];
  logic signed [SumW-1:0] acc_q [NumAcc];
  logic                   clipped_q;
  scatter_sums_t          open_sets_q [$];
  int                     mismatches = 0;
  int                     pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_sums_o   = pending;

  function automatic logic signed [DataW-1:0] center_coord(input logic [DataW-1:0] coord,
                                                           input logic [DataW-1:0] mean,
                                                           output logic clipped);
    logic signed [SumW-1:0] c;
    logic signed [SumW-1:0] d;
    c = $signed(coord[COORD_WIDTH-1:0]);
    d = ((c * $signed({32'b0, scale_q})) >>> 16) - $signed(mean);
    clipped = (d > CenterMax) || (d < CenterMin);
    if (d > CenterMax) begin
      d = CenterMax;
    end else if (d < CenterMin) begin
      d = CenterMin;
    end
    return d[DataW-1:0];
  endfunction

  function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] a,
                                                     input logic signed [SumW-1:0] p,
                                                     output logic clipped);
    logic signed [SumW:0] t;
    t = a + p;
    clipped = t[SumW] != t[SumW-1];
    return clipped ? {t[SumW], {(SumW-1){~t[SumW]}}} : t[SumW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [SumW-1:0] want,
                                 input logic [SumW-1:0] got);
    $display("%0t %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic absorb_point(input logic [DataW-1:0] u, input logic [DataW-1:0] v,
                              input logic [DataW-1:0] w, input logic is_last);
    logic signed [SumW-1:0] cen [NumScale];
    logic                   clip;
    scatter_sums_t          done;
    cen[0] = center_coord(u, mean_q[0], clip);
    clipped_q |= clip;
    cen[1] = center_coord(v, mean_q[1], clip);
    clipped_q |= clip;
    cen[2] = center_coord(w, mean_q[2], clip);
    clipped_q |= clip;
    for (int k = 0; k < NumAcc; k++) begin
      acc_q[k] = sat_add(acc_q[k], cen[FactorA[k]] * cen[FactorB[k]], clip);
      clipped_q |= clip;
    end
    if (is_last) begin
      for (int k = 0; k < NumAcc; k++) begin
        done.sums[k] = acc_q[k];
        acc_q[k] = '0;
      end
      done.overflow = clipped_q;
      clipped_q = 1'b0;
      open_sets_q.push_back(done);
    end
  endtask

  task automatic compare_sums();
    scatter_sums_t want;
    scatter_sums_t got;
    got.sums = {sum_ww_i, sum_wv_i, sum_wu_i, sum_vv_i, sum_vu_i, sum_uu_i};
    got.overflow = overflow_i;
    if (open_sets_q.size() == 0) begin
      report_mismatch("result word with no set pending", '0, got.sums[0]);
      return;
    end
    want = open_sets_q.pop_front();
    for (int k = 0; k < NumAcc; k++) begin
      if (got.sums[k] !== want.sums[k]) begin
        report_mismatch(SumNames[k], want.sums[k], got.sums[k]);
      end
    end
    if (got.overflow !== want.overflow) begin
      report_mismatch("overflow", SumW'(want.overflow), SumW'(got.overflow));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   = ScaleReset;
      mean_q    = '{default: '0};
      acc_q     = '{default: '0};
      clipped_q = 1'b0;
      open_sets_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCALE:  scale_q   = cfg_wdata_i;
          REG_MEAN_U: mean_q[0] = cfg_wdata_i;
          REG_MEAN_V: mean_q[1] = cfg_wdata_i;
          REG_MEAN_W: mean_q[2] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        absorb_point(coord_u_i, coord_v_i, coord_w_i, last_i);
      end
      if (out_valid_i && out_ready_i) begin
        compare_sums();
      end
    end
    pending = open_sets_q.size();
  end

endmodule

// ----- tb/sv/scatter_matrix_3d_accumulator_tb.sv -----
`timescale 1ns / 1ps

module scatter_matrix_3d_accumulator_tb;
  import smacc_pkg::*;

  localparam int unsigned CoordW        = 32;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned RandomItems   = 1850;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned FirstSpareReg = int'(REG_MEAN_W) + 1;
  localparam int unsigned LastSpareReg  = 2 ** CfgIdxW - 1;

  localparam logic [DataW-1:0] MaxQ    = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] MinQ    = 32'h8000_0000;
  localparam logic [DataW-1:0] OneQ    = 32'h0001_0000;
  localparam logic [DataW-1:0] AllOnes = 32'hFFFF_FFFF;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [DataW-1:0]   coord_u_i;
  logic [DataW-1:0]   coord_v_i;
  logic [DataW-1:0]   coord_w_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SumW-1:0]    sum_uu_o;
  logic [SumW-1:0]    sum_vu_o;
  logic [SumW-1:0]    sum_vv_o;
  logic [SumW-1:0]    sum_wu_o;
  logic [SumW-1:0]    sum_wv_o;
  logic [SumW-1:0]    sum_ww_o;
  logic               overflow_o;

  int                 mismatches;
  int                 pending_sums;
  int unsigned        idle_cycles;
  bit                 idle_in;
  bit                 idle_out;

  scatter_matrix_3d_accumulator #(
    .COORD_WIDTH(CoordW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .coord_u_i  (coord_u_i),
    .coord_v_i  (coord_v_i),
    .coord_w_i  (coord_w_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sum_uu_o   (sum_uu_o),
    .sum_vu_o   (sum_vu_o),
    .sum_vv_o   (sum_vv_o),
    .sum_wu_o   (sum_wu_o),
    .sum_wv_o   (sum_wv_o),
    .sum_ww_o   (sum_ww_o),
    .overflow_o (overflow_o)
  );

  scatter_matrix_3d_accumulator_checker #(
    .COORD_WIDTH(CoordW)
  ) sum_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .coord_u_i       (coord_u_i),
    .coord_v_i       (coord_v_i),
    .coord_w_i       (coord_w_i),
    .last_i          (last_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sum_uu_i        (sum_uu_o),
    .sum_vu_i        (sum_vu_o),
    .sum_vv_i        (sum_vv_o),
    .sum_wu_i        (sum_wu_o),
    .sum_wv_i        (sum_wv_o),
    .sum_ww_i        (sum_ww_o),
    .overflow_i      (overflow_o),
    .mismatch_count_o(mismatches),
    .pending_sums_o  (pending_sums)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_out && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [DataW-1:0] pick_coord(input int unsigned mode);
    logic [DataW-1:0] r;
    r = $urandom;
    if (mode < 6) begin
      return $signed(r) >>> $urandom_range(8, 28);
    end
    if (mode < 8) begin
      return r;
    end
    case ($urandom_range(0, 4))
      0:       return MinQ;
      1:       return MaxQ;
      2:       return '0;
      3:       return AllOnes;
      default: return OneQ;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_mean();
    logic [DataW-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return MinQ;
      1:       return MaxQ;
      2:       return '0;
      3:       return r;
      default: return $signed(r) >>> $urandom_range(8, 20);
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return AllOnes;
      2:       return 32'd1;
      3:       return OneQ;
      4:       return $urandom;
      default: return $urandom_range(32'h0000_8000, 32'h0002_0000);
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_point(input logic [DataW-1:0] u, input logic [DataW-1:0] v,
                            input logic [DataW-1:0] w, input logic is_last);
    @(negedge clk_i);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_u_i  <= u;
    coord_v_i  <= v;
    coord_w_i  <= w;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // A word without last may still be in flight after the final result has left.
  task automatic await_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_sums != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic configure_random();
    write_reg(REG_SCALE, pick_scale());
    write_reg(REG_MEAN_U, pick_mean());
    write_reg(REG_MEAN_V, pick_mean());
    write_reg(REG_MEAN_W, pick_mean());
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CfgIdxW'($urandom_range(FirstSpareReg, LastSpareReg)), $urandom);
    end
  endtask

  task automatic run_sets(input int unsigned budget, input bit calm);
    int unsigned sent;
    int unsigned len;
    int unsigned mode;
    sent = 0;
    while (sent < budget) begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      mode     = $urandom_range(0, 9);
      idle_in  = !calm && $urandom_range(0, 3) != 0;
      idle_out = !calm && $urandom_range(0, 3) != 0;
      for (int i = 0; i < len; i++) begin
        send_point(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 24) == 0) begin
        await_results();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    coord_u_i   = '0;
    coord_v_i   = '0;
    coord_w_i   = '0;
    last_i      = 1'b0;
    idle_in     = 1'b1;
    idle_out    = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_point('0, '0, '0, 1'b1);
    send_point(MinQ, MinQ, MaxQ, 1'b0);
    send_point(MinQ, MinQ, MaxQ, 1'b0);
    send_point(MinQ, MaxQ, MaxQ, 1'b0);
    send_point(MaxQ, MinQ, MaxQ, 1'b1);
    await_results();

    write_reg(REG_SCALE, AllOnes);
    write_reg(REG_MEAN_U, MinQ);
    write_reg(REG_MEAN_V, MaxQ);
    write_reg(REG_MEAN_W, '0);
    write_reg(CfgIdxW'(FirstSpareReg), $urandom);
    write_reg(CfgIdxW'(LastSpareReg), $urandom);
    send_point('0, '0, '0, 1'b1);
    send_point(MaxQ, MinQ, 32'd1, 1'b0);
    send_point(MinQ, MaxQ, AllOnes, 1'b1);
    send_point(32'd1, AllOnes, 32'h0000_8000, 1'b1);
    await_results();

    write_reg(REG_SCALE, 32'd1);
    write_reg(REG_MEAN_U, 32'd1);
    write_reg(REG_MEAN_V, AllOnes);
    write_reg(REG_MEAN_W, '0);
    send_point(AllOnes, 32'd1, 32'h0000_FFFF, 1'b1);
    send_point(32'hFFFF_0000, OneQ, MinQ, 1'b0);
    send_point(MaxQ, 32'h0000_FFFF, MinQ, 1'b1);
    await_results();

    write_reg(REG_SCALE, '0);
    write_reg(REG_MEAN_U, MaxQ);
    write_reg(REG_MEAN_V, MinQ);
    write_reg(REG_MEAN_W, $urandom);
    send_point(MaxQ, MinQ, '0, 1'b0);
    send_point(MinQ, MaxQ, AllOnes, 1'b1);
    await_results();

    for (int p = 0; p < RandomPhases; p++) begin
      configure_random();
      run_sets(RandomItems / RandomPhases, p == RandomPhases - 1);
      await_results();
    end

    if (mismatches == 0 && pending_sums == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- scatter_matrix_3d_accumulator.f -----
hw/rtl/smacc_pkg.sv
hw/rtl/smacc_ctrl.sv
hw/rtl/smacc_dp.sv
hw/rtl/scatter_matrix_3d_accumulator.sv
tb/sv/scatter_matrix_3d_accumulator_checker.sv
tb/sv/scatter_matrix_3d_accumulator_tb.sv
